// ===== sv/assert_macros.svh =====
// assertion macros shared by the frame parser modules
// no dependencies; included by every file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== sv/ufp_pkg.sv =====
// types and constants for the frame parser
// no dependencies; imported by all parser modules
package ufp_pkg;

	localparam logic [7:0]  SYNC1_BYTE  = 8'hB5;
	localparam logic [7:0]  SYNC2_BYTE  = 8'h62;
	localparam logic [15:0] LIMIT_RESET = 16'd512;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_CLASS,
		PH_ID,
		PH_LEN1,
		PH_LEN2,
		PH_PAYLOAD,
		PH_CHECK1,
		PH_CHECK2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_GOOD,
		KIND_FAIL
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [15:0] payload_length;
		logic [15:0] byte_index;
		logic [7:0]  byte_value;
		logic [15:0] error_total;
	} result_t;

	// queue occupancy as seen by the two sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== sv/ufp_front.sv =====
// front end: frame state machine, checksum and length check
// depends on ufp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ufp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       byte_in,
	input  logic             limit_we,
	input  logic [15:0]      limit_wdata,
	output logic             push,
	output ufp_pkg::result_t push_data
);
	import ufp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] limit_q;
	logic [7:0]  class_q, id_q;
	logic [15:0] length_q, count_q, fail_q;
	logic [7:0]  sum_a_q, sum_b_q;

	logic [7:0]  sum_a_n, sum_b_n;
	logic [15:0] len_full, thresh, count_inc, fail_inc;
	logic        drop;

	assign sum_a_n   = sum_a_q + byte_in;
	assign sum_b_n   = sum_b_q + sum_a_n;
	assign len_full  = {byte_in, length_q[7:0]};
	assign thresh    = (limit_q == 16'd0) ? 16'd0 : limit_q - 16'd1;
	assign drop      = len_full >= thresh;
	assign count_inc = count_q + 16'd1;
	assign fail_inc  = fail_q + 16'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_SYNC1:   if (byte_in == SYNC1_BYTE) phase_d = PH_SYNC2;
			PH_SYNC2:   phase_d = (byte_in == SYNC2_BYTE) ? PH_CLASS : PH_SYNC1;
			PH_CLASS:   phase_d = PH_ID;
			PH_ID:      phase_d = PH_LEN1;
			PH_LEN1:    phase_d = PH_LEN2;
			PH_LEN2: begin
				if (drop)
					phase_d = PH_SYNC1;
				else if (len_full != 16'd0)
					phase_d = PH_PAYLOAD;
				else
					phase_d = PH_CHECK1;
			end
			PH_PAYLOAD: if (count_inc == length_q) phase_d = PH_CHECK1;
			PH_CHECK1:  phase_d = (byte_in == sum_a_q) ? PH_CHECK2 : PH_SYNC1;
			PH_CHECK2:  phase_d = PH_SYNC1;
			default:    phase_d = PH_SYNC1;
		endcase
	end

	// result toward the queue
	always_comb begin
		push                     = 1'b0;
		push_data.kind           = KIND_BYTE;
		push_data.msg_class      = class_q;
		push_data.msg_id         = id_q;
		push_data.payload_length = length_q;
		push_data.byte_index     = 16'd0;
		push_data.byte_value     = 8'd0;
		push_data.error_total    = fail_q;
		case (phase_q)
			PH_PAYLOAD: begin
				push                 = accept;
				push_data.byte_index = count_q;
				push_data.byte_value = byte_in;
			end
			PH_CHECK1: begin
				if (byte_in != sum_a_q) begin
					push                  = accept;
					push_data.kind        = KIND_FAIL;
					push_data.error_total = fail_inc;
				end
			end
			PH_CHECK2: begin
				push = accept;
				if (byte_in == sum_b_q) begin
					push_data.kind = KIND_GOOD;
				end else begin
					push_data.kind        = KIND_FAIL;
					push_data.error_total = fail_inc;
				end
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			limit_q  <= LIMIT_RESET;
			class_q  <= 8'd0;
			id_q     <= 8'd0;
			length_q <= 16'd0;
			count_q  <= 16'd0;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
			fail_q   <= 16'd0;
		end else begin
			if (limit_we)
				limit_q <= limit_wdata;
			if (accept) begin
				phase_q <= phase_d;
				case (phase_q)
					PH_CLASS: begin
						class_q <= byte_in;
						sum_a_q <= byte_in;
						sum_b_q <= byte_in;
					end
					PH_ID: begin
						id_q    <= byte_in;
						sum_a_q <= sum_a_n;
						sum_b_q <= sum_b_n;
					end
					PH_LEN1: begin
						length_q <= {8'd0, byte_in};
						sum_a_q  <= sum_a_n;
						sum_b_q  <= sum_b_n;
					end
					PH_LEN2: begin
						length_q <= drop ? 16'd0 : len_full;
						count_q  <= 16'd0;
						sum_a_q  <= sum_a_n;
						sum_b_q  <= sum_b_n;
					end
					PH_PAYLOAD: begin
						count_q <= count_inc;
						sum_a_q <= sum_a_n;
						sum_b_q <= sum_b_n;
					end
					PH_CHECK1: if (byte_in != sum_a_q) fail_q <= fail_inc;
					PH_CHECK2: if (byte_in != sum_b_q) fail_q <= fail_inc;
					default: ;
				endcase
			end
		end
	end

	`ASSERT_IMPLIES(a_push_phase, clk, arst_n, push, (phase_q == PH_PAYLOAD || phase_q == PH_CHECK1 || phase_q == PH_CHECK2))
	`ASSERT_NEXT(a_check2_ends, clk, arst_n, accept && phase_q == PH_CHECK2, phase_q == PH_SYNC1)
	`ASSERT_IMPLIES(a_payload_len, clk, arst_n, phase_q == PH_PAYLOAD, length_q != 16'd0)

endmodule

// ===== sv/ufp_queue.sv =====
// short result queue between parser front end and output stage
// depends on ufp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ufp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ufp_pkg::result_t    push_data,
	input  logic                pop,
	output ufp_pkg::result_t    pop_data,
	output ufp_pkg::q_status_t  status
);
	import ufp_pkg::*;

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push, do_pop;

	assign status.full  = count_q == (QPTR_W+1)'(QDEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(push && status.full))
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= (QPTR_W+1)'(QDEPTH))
	`ASSERT_ALWAYS(a_ptr_count, clk, arst_n, (wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])

endmodule

// ===== sv/ufp_back.sv =====
// output stage: registered result, drains the queue
// depends on ufp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ufp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ufp_pkg::q_status_t q_status,
	input  ufp_pkg::result_t   q_data,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output ufp_pkg::result_t   result_data
);
	import ufp_pkg::*;

	logic    valid_q;
	result_t data_q;
	logic    load;

	// output register may take a new entry when empty or being drained
	assign load         = !valid_q || !result_stall;
	assign pop          = load && !q_status.empty;
	assign result_valid = valid_q;
	assign result_data  = data_q;

	always_ff @(posedge clk) begin
		if (pop)
			data_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= !q_status.empty;
	end

	`ASSERT_NEXT(a_pop_shows, clk, arst_n, pop, valid_q)
	`ASSERT_NEXT(a_idle_when_drained, clk, arst_n, (!valid_q || !result_stall) && q_status.empty, !valid_q)

endmodule

// ===== sv/ubx_frame_parser.sv =====
// top level of the binary gnss frame parser
// depends on ufp_pkg, ufp_front, ufp_queue, ufp_back
//
// Usage: bytes from the serial deserializer enter on byte_in with byte_valid;
// a transfer happens on a rising edge with byte_valid high and byte_stall low.
// Results leave on the result channel the same way (result_valid, result_stall)
// with one port per field: kind, msg_class, msg_id, payload_length,
// byte_index, byte_value, error_total.
// The length limit is written with limit_we / limit_wdata, while idle.
// Throughput: one byte per cycle while byte_stall is low, set by the frame
// state machine in the front end. A result is written into the queue when the
// byte that causes it is transferred and then moves into the output register.
// A four-entry queue sits between front end and output register; byte_stall is
// high only when that queue is full, so a stalled receiver blocks the input
// after at most five results have piled up (queue plus output register).
// Reset clears the frame state, the error count and the queue, sets the length
// limit to 512 and starts hunting for the first sync byte.

module ubx_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_in,
	input  logic        limit_we,
	input  logic [15:0] limit_wdata,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  msg_class,
	output logic [7:0]  msg_id,
	output logic [15:0] payload_length,
	output logic [15:0] byte_index,
	output logic [7:0]  byte_value,
	output logic [15:0] error_total
);
	import ufp_pkg::*;

	logic      accept, push, pop;
	result_t   push_data, q_data, result_data;
	q_status_t q_status;

	assign byte_stall = q_status.full;
	assign accept     = byte_valid && !byte_stall;

	ufp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_in    (byte_in),
		.limit_we   (limit_we),
		.limit_wdata(limit_wdata),
		.push       (push),
		.push_data  (push_data)
	);

	ufp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (q_data),
		.status   (q_status)
	);

	ufp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.q_data      (q_data),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	assign kind           = result_data.kind;
	assign msg_class      = result_data.msg_class;
	assign msg_id         = result_data.msg_id;
	assign payload_length = result_data.payload_length;
	assign byte_index     = result_data.byte_index;
	assign byte_value     = result_data.byte_value;
	assign error_total    = result_data.error_total;

endmodule
